### rtl/cobs_sr_pkg.sv
package cobs_sr_pkg;

    localparam int BYTE_W     = 8;
    localparam int BUF_DEPTH  = 32;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int CODE_W     = FILL_W + 1;
    localparam int MAX_RUN    = 16;
    localparam int PEND_W     = $clog2(MAX_RUN);
    localparam int DEPTH_W    = 6;
    localparam int RUN_W      = 5;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELIM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_BYTE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN   = 3'd4;

    localparam logic [1:0] CMD_MISS  = 2'd0;
    localparam logic [1:0] CMD_HIT   = 2'd1;
    localparam logic [1:0] CMD_FIN   = 2'd2;
    localparam logic [1:0] CMD_DELIM = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]  delimiter_value;
        logic [DEPTH_W-1:0] block_depth;
        logic               replace_enable;
        logic [BYTE_W-1:0]  run_byte;
        logic [RUN_W-1:0]   run_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    function automatic logic [FILL_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
        logic [FILL_W-1:0] r;
        if (d < DEPTH_W'(2)) begin
            r = FILL_W'(2);
        end else if (d > DEPTH_W'(BUF_DEPTH)) begin
            r = FILL_W'(BUF_DEPTH);
        end else begin
            r = FILL_W'(d);
        end
        return r;
    endfunction

    function automatic logic [RUN_W-1:0] eff_run(input logic [RUN_W-1:0] l);
        logic [RUN_W-1:0] r;
        if (l == '0) begin
            r = RUN_W'(1);
        end else if (l > RUN_W'(MAX_RUN)) begin
            r = RUN_W'(MAX_RUN);
        end else begin
            r = l;
        end
        return r;
    endfunction

endpackage

### rtl/cobs_sr_front.sv
module cobs_sr_front (
    input  logic                                 i_valid,
    input  logic [cobs_sr_pkg::ACT_W-1:0]        i_action,
    input  logic [cobs_sr_pkg::BYTE_W-1:0]       i_data_byte,
    input  cobs_sr_pkg::t_cfg                    i_cfg,
    input  logic                                 i_q_full,
    output logic                                 o_stall,
    output logic                                 o_push,
    output cobs_sr_pkg::t_cmd                    o_cmd
);

    always_comb begin
        o_stall    = i_q_full;
        o_push     = 1'b0;
        o_cmd.data = i_data_byte;
        o_cmd.kind = cobs_sr_pkg::CMD_MISS;
        case (i_action)
            cobs_sr_pkg::ACT_WRITE: begin
                o_push = i_valid && !i_q_full;
                if (i_cfg.replace_enable && (i_data_byte == i_cfg.run_byte)) begin
                    o_cmd.kind = cobs_sr_pkg::CMD_HIT;
                end
            end
            cobs_sr_pkg::ACT_FINISH: begin
                o_push     = i_valid && !i_q_full;
                o_cmd.kind = cobs_sr_pkg::CMD_FIN;
            end
            cobs_sr_pkg::ACT_DELIM: begin
                o_push     = i_valid && !i_q_full;
                o_cmd.kind = cobs_sr_pkg::CMD_DELIM;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

### rtl/cobs_sr_cmdq.sv
module cobs_sr_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cobs_sr_pkg::t_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output cobs_sr_pkg::t_cmd o_cmd,
    input  logic              i_pop
);

    cobs_sr_pkg::t_cmd                     r_mem [cobs_sr_pkg::CMDQ_DEPTH];
    logic [cobs_sr_pkg::CMDQ_PTR_W-1:0]    r_wr_ptr;
    logic [cobs_sr_pkg::CMDQ_PTR_W-1:0]    r_rd_ptr;
    logic [cobs_sr_pkg::CMDQ_CNT_W-1:0]    r_count;
    logic                                  do_pop;

    assign o_full  = (r_count == cobs_sr_pkg::CMDQ_CNT_W'(cobs_sr_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cobs_sr_pkg::CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cobs_sr_pkg::CMDQ_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + cobs_sr_pkg::CMDQ_CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - cobs_sr_pkg::CMDQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/cobs_sr_back.sv
module cobs_sr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cobs_sr_pkg::t_cfg               i_cfg,
    input  logic                            i_cmd_valid,
    input  cobs_sr_pkg::t_cmd               i_cmd,
    output logic                            o_cmd_pop,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [cobs_sr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                            o_last_of_run
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REPLAY = 3'd1;
    localparam logic [2:0] ST_ENC    = 3'd2;
    localparam logic [2:0] ST_FFIN   = 3'd3;
    localparam logic [2:0] ST_FCODE  = 3'd4;
    localparam logic [2:0] ST_FDATA  = 3'd5;
    localparam logic [2:0] ST_DELIM  = 3'd6;

    localparam int BW = cobs_sr_pkg::BYTE_W;
    localparam int FW = cobs_sr_pkg::FILL_W;
    localparam int AW = cobs_sr_pkg::ADDR_W;
    localparam int CW = cobs_sr_pkg::CODE_W;
    localparam int PW = cobs_sr_pkg::PEND_W;
    localparam int RW = cobs_sr_pkg::RUN_W;

    logic [BW-1:0] r_buf [cobs_sr_pkg::BUF_DEPTH];
    logic [BW-1:0] r_rdata;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_ret, n_ret;
    logic [1:0]    r_kind, n_kind;
    logic [BW-1:0] r_byte, n_byte;
    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_pend, n_pend;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_code, n_code;
    logic [BW-1:0] r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    logic          r_ov, n_ov;
    logic [BW-1:0] r_obyte, n_obyte;
    logic          r_olast, n_olast;

    logic [FW-1:0] depth;
    logic [RW-1:0] run;
    logic          out_free;
    logic          can_emit;
    logic          emit_en;
    logic [BW-1:0] emit_byte;
    logic          last_en;
    logic          push_en;
    logic          mem_we;
    logic [BW-1:0] enc_x;
    logic [2:0]    enc_follow;
    logic [FW-1:0] fill_inc;
    logic [RW-1:0] pend_inc;
    logic [FW-1:0] idx_inc;
    logic [BW-1:0] code_byte;

    assign depth      = cobs_sr_pkg::eff_depth(i_cfg.block_depth);
    assign run        = cobs_sr_pkg::eff_run(i_cfg.run_length);
    assign out_free   = !r_ov || !i_stall;
    assign can_emit   = !r_hold_v || out_free;
    assign fill_inc   = r_fill + FW'(1);
    assign pend_inc   = RW'(r_pend) + RW'(1);
    assign idx_inc    = FW'(r_idx) + FW'(1);

    always_comb begin
        code_byte = BW'(r_code);
        if ((i_cfg.delimiter_value != '0) && (code_byte == i_cfg.delimiter_value)) begin
            code_byte = '0;
        end
    end

    always_comb begin
        enc_x      = (r_state == ST_ENC) ? r_byte : i_cfg.run_byte;
        enc_follow = ST_IDLE;
        if (r_state == ST_REPLAY) begin
            if (r_pend != PW'(1)) begin
                enc_follow = ST_REPLAY;
            end else if (r_kind == cobs_sr_pkg::CMD_FIN) begin
                enc_follow = ST_FFIN;
            end else begin
                enc_follow = ST_ENC;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_fill    = r_fill;
        n_pend    = r_pend;
        n_idx     = r_idx;
        n_code    = r_code;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        emit_en   = 1'b0;
        emit_byte = code_byte;
        last_en   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (can_emit) begin
                    last_en = r_hold_v;
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        n_kind    = i_cmd.kind;
                        n_byte    = i_cmd.data;
                        case (i_cmd.kind)
                            cobs_sr_pkg::CMD_DELIM: begin
                                n_state = ST_DELIM;
                            end
                            cobs_sr_pkg::CMD_HIT: begin
                                if (pend_inc >= run) begin
                                    n_code  = CW'(r_fill) + CW'(depth);
                                    n_ret   = ST_IDLE;
                                    n_pend  = '0;
                                    n_state = ST_FCODE;
                                end else begin
                                    n_pend = pend_inc[PW-1:0];
                                end
                            end
                            cobs_sr_pkg::CMD_FIN: begin
                                n_state = (r_pend != '0) ? ST_REPLAY : ST_FFIN;
                            end
                            default: begin
                                n_state = (r_pend != '0) ? ST_REPLAY : ST_ENC;
                            end
                        endcase
                    end
                end
            end
            ST_REPLAY, ST_ENC: begin
                if (r_state == ST_REPLAY) begin
                    n_pend = r_pend - PW'(1);
                end
                if (enc_x != i_cfg.delimiter_value) begin
                    mem_we = 1'b1;
                    n_fill = fill_inc;
                    if (fill_inc >= depth) begin
                        n_code  = CW'(fill_inc);
                        n_ret   = enc_follow;
                        n_state = ST_FCODE;
                    end else begin
                        n_state = enc_follow;
                    end
                end else begin
                    n_code  = CW'(r_fill);
                    n_ret   = enc_follow;
                    n_state = ST_FCODE;
                end
            end
            ST_FFIN: begin
                n_code  = CW'(r_fill);
                n_ret   = ST_DELIM;
                n_state = ST_FCODE;
            end
            ST_FCODE: begin
                n_idx = AW'(1);
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = code_byte;
                    n_state   = (r_fill == FW'(1)) ? r_ret : ST_FDATA;
                end
            end
            ST_FDATA: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = r_rdata;
                    if (idx_inc == r_fill) begin
                        n_fill  = FW'(1);
                        n_state = r_ret;
                    end else begin
                        n_idx = idx_inc[AW-1:0];
                    end
                end
            end
            ST_DELIM: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = i_cfg.delimiter_value;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        push_en  = (emit_en && r_hold_v) || last_en;
        if (emit_en) begin
            n_hold   = emit_byte;
            n_hold_v = 1'b1;
        end else if (last_en) begin
            n_hold_v = 1'b0;
        end
        n_ov    = r_ov;
        n_obyte = r_obyte;
        n_olast = r_olast;
        if (push_en) begin
            n_ov    = 1'b1;
            n_obyte = r_hold;
            n_olast = last_en;
        end else if (!i_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= FW'(1);
            r_pend   <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_idx   <= n_idx;
        r_code  <= n_code;
        r_hold  <= n_hold;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_buf[r_fill[AW-1:0]] <= enc_x;
        end
        r_rdata <= r_buf[n_idx];
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;

endmodule

### rtl/cobs_sr_stream_encoder_top.sv
// Input commands wait in the command queue, so new input can be taken while the encoder
// sequencer is still busy; the input stalls when the queue is full. A data byte that is not
// the delimiter is stored in the block buffer, as is each replayed run byte; a flushed block is
// sent as its code byte and then its data bytes, one byte per cycle while the output is not stalled.
// Reset is synchronous and active low: it restores the register defaults, empties the queue
// and output stage, and sets the fill position to one; the block buffer is not cleared.
module cobs_sr_stream_encoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cobs_sr_pkg::ACT_W-1:0]        i_action,
    input  logic [cobs_sr_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [cobs_sr_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                                 o_last_of_run,
    input  logic                                 i_cfg_we,
    input  logic [cobs_sr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cobs_sr_pkg::BYTE_W-1:0]       i_cfg_data
);

    cobs_sr_pkg::t_cfg r_cfg;
    cobs_sr_pkg::t_cmd front_cmd;
    cobs_sr_pkg::t_cmd q_cmd;
    logic              front_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_value <= '0;
            r_cfg.block_depth     <= cobs_sr_pkg::DEPTH_W'(32);
            r_cfg.replace_enable  <= 1'b0;
            r_cfg.run_byte        <= '0;
            r_cfg.run_length      <= cobs_sr_pkg::RUN_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cobs_sr_pkg::CFG_DELIMITER: begin
                    r_cfg.delimiter_value <= i_cfg_data;
                end
                cobs_sr_pkg::CFG_DEPTH: begin
                    r_cfg.block_depth <= i_cfg_data[cobs_sr_pkg::DEPTH_W-1:0];
                end
                cobs_sr_pkg::CFG_REPLACE: begin
                    r_cfg.replace_enable <= i_cfg_data[0];
                end
                cobs_sr_pkg::CFG_RUN_BYTE: begin
                    r_cfg.run_byte <= i_cfg_data;
                end
                cobs_sr_pkg::CFG_RUN_LEN: begin
                    r_cfg.run_length <= i_cfg_data[cobs_sr_pkg::RUN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cobs_sr_front u_front (
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    cobs_sr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    cobs_sr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### sim/cobs_sr_stream_encoder_top_tb.sv
module cobs_sr_stream_encoder_top_tb;

    localparam logic [cobs_sr_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int OUT_CAP = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [cobs_sr_pkg::ACT_W-1:0]  action;
        logic [cobs_sr_pkg::BYTE_W-1:0] data;
    } t_enc_cmd;

    typedef struct packed {
        logic [cobs_sr_pkg::BYTE_W-1:0] out_byte;
        logic                           last;
    } t_coded_beat;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [cobs_sr_pkg::ACT_W-1:0]       i_action = cobs_sr_pkg::ACT_WRITE;
    logic [cobs_sr_pkg::BYTE_W-1:0]      i_data_byte = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [cobs_sr_pkg::BYTE_W-1:0]      o_out_byte;
    logic                                o_last_of_run;
    logic                                i_cfg_we = 1'b0;
    logic [cobs_sr_pkg::CFG_IDX_W-1:0]   i_cfg_idx = cobs_sr_pkg::CFG_DELIMITER;
    logic [cobs_sr_pkg::BYTE_W-1:0]      i_cfg_data = '0;

    // Encoder state as the predictor sees it.
    logic [7:0] cfg_delim = 8'h00;
    logic [5:0] cfg_depth = 6'd32;
    logic       cfg_replace = 1'b0;
    logic [7:0] cfg_run_byte = 8'h00;
    logic [4:0] cfg_run_len = 5'd2;
    logic [7:0] blk_buf [cobs_sr_pkg::BUF_DEPTH];
    int         fill_pos = 1;
    int         run_pend = 0;
    int         item_results;

    t_coded_beat coded_q[$];
    t_enc_cmd    pending_cmds[$];

    int cmds_issued = 0;
    int cmds_accepted = 0;
    int beats_checked = 0;
    int mismatch_count = 0;
    int settings_used = 1;
    int hold_trigger = 32'h7FFF_FFFF;
    int hold_left = 0;
    int src_gap = 0;
    int snk_gap = 0;
    bit hold_done = 1'b0;
    bit in_taken = 1'b0;
    bit quiet = 1'b0;

    cobs_sr_stream_encoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int depth_limit();
        int d;
        d = cfg_depth;
        if (d < 2) d = 2;
        if (d > cobs_sr_pkg::BUF_DEPTH) d = cobs_sr_pkg::BUF_DEPTH;
        return d;
    endfunction

    function automatic int run_target();
        int r;
        r = cfg_run_len;
        if (r < 1) r = 1;
        if (r > cobs_sr_pkg::MAX_RUN) r = cobs_sr_pkg::MAX_RUN;
        return r;
    endfunction

    function automatic void push_coded(input logic [7:0] b);
        if (item_results < OUT_CAP) begin
            coded_q.push_back('{b, 1'b0});
            item_results++;
        end
    endfunction

    function automatic void flush_block(input int code);
        logic [7:0] c;
        c = 8'(code);
        if (cfg_delim != 8'h00 && c == cfg_delim) c = 8'h00;
        blk_buf[0] = c;
        for (int i = 0; i < fill_pos && i < cobs_sr_pkg::BUF_DEPTH; i++) begin
            push_coded(blk_buf[i]);
        end
        fill_pos = 1;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (b != cfg_delim) begin
            if (fill_pos < cobs_sr_pkg::BUF_DEPTH) blk_buf[fill_pos] = b;
            fill_pos++;
            if (fill_pos < depth_limit()) return;
        end
        flush_block(fill_pos);
    endfunction

    function automatic void replay_run();
        while (run_pend != 0) begin
            store_byte(cfg_run_byte);
            run_pend--;
        end
    endfunction

    function automatic void encode_cmd(input logic [cobs_sr_pkg::ACT_W-1:0] act,
                                       input logic [7:0] b);
        t_coded_beat tail;
        item_results = 0;
        case (act)
            cobs_sr_pkg::ACT_WRITE: begin
                if (cfg_replace && b == cfg_run_byte && fill_pos <= 255 - depth_limit()) begin
                    run_pend++;
                    if (run_pend >= run_target()) begin
                        flush_block(fill_pos + depth_limit());
                        run_pend = 0;
                    end
                end else begin
                    replay_run();
                    store_byte(b);
                end
            end
            cobs_sr_pkg::ACT_FINISH: begin
                replay_run();
                flush_block(fill_pos);
                push_coded(cfg_delim);
            end
            cobs_sr_pkg::ACT_DELIM: begin
                push_coded(cfg_delim);
            end
            default: ;
        endcase
        if (item_results > 0) begin
            tail = coded_q.pop_back();
            tail.last = 1'b1;
            coded_q.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_coded_beat want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                encode_cmd(i_action, i_data_byte);
                cmds_accepted++;
                in_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (coded_q.size() == 0) begin
                    $error("out_byte: expected no beat, got %h", o_out_byte);
                    mismatch_count++;
                end else begin
                    want = coded_q.pop_front();
                    beats_checked++;
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, o_out_byte);
                        mismatch_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, o_last_of_run);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_enc_cmd cmd;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(1, 19) - 1;
                i_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd = pending_cmds.pop_front();
                i_valid <= 1'b1;
                i_action <= cmd.action;
                i_data_byte <= cmd.data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the block back up until it stalls its input.
    always @(negedge i_clk) begin
        if (!hold_done && cmds_accepted >= hold_trigger) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            snk_gap = $urandom_range(1, 19) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic queue_cmd(input logic [cobs_sr_pkg::ACT_W-1:0] act, input logic [7:0] b);
        pending_cmds.push_back('{act, b});
        cmds_issued++;
    endtask

    task automatic write_reg(input logic [cobs_sr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] delim, input logic [5:0] depth,
                             input logic rep, input logic [7:0] rb, input logic [4:0] rl);
        write_reg(cobs_sr_pkg::CFG_DELIMITER, delim);
        write_reg(cobs_sr_pkg::CFG_DEPTH, 8'(depth));
        write_reg(cobs_sr_pkg::CFG_REPLACE, 8'(rep));
        write_reg(cobs_sr_pkg::CFG_RUN_BYTE, rb);
        write_reg(cobs_sr_pkg::CFG_RUN_LEN, 8'(rl));
        i_cfg_we <= 1'b0;
        cfg_delim = delim;
        cfg_depth = depth;
        cfg_replace = rep;
        cfg_run_byte = rb;
        cfg_run_len = rl;
        settings_used++;
    endtask

    task automatic drain();
        while (cmds_accepted != cmds_issued || coded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly data and runs of the run byte, closed now and then by a finish or a delimiter.
    task automatic random_phase(input int n);
        int made;
        int r;
        int len;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_cmd(cobs_sr_pkg::ACT_FINISH, 8'($urandom));
                made++;
            end else if (r < 12) begin
                queue_cmd(cobs_sr_pkg::ACT_DELIM, 8'($urandom));
                made++;
            end else if (r < 14) begin
                queue_cmd(ACT_UNUSED, 8'($urandom));
            end else if (r < 32) begin
                len = $urandom_range(1, run_target() + 1);
                repeat (len) queue_cmd(cobs_sr_pkg::ACT_WRITE, cfg_run_byte);
                made += len;
            end else if (r < 40) begin
                queue_cmd(cobs_sr_pkg::ACT_WRITE, cfg_delim);
                made++;
            end else begin
                queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'($urandom));
                made++;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] delim;
        logic [5:0] depth;
        logic       rep;
        logic [7:0] rb;
        logic [4:0] rl;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h00);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'hFF);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h01);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h80);
        queue_cmd(ACT_UNUSED, 8'h55);
        queue_cmd(cobs_sr_pkg::ACT_FINISH, 8'hAA);
        queue_cmd(cobs_sr_pkg::ACT_DELIM, 8'h00);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h7F);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h00);
        drain();

        // A code equal to a non-zero delimiter, then a partly filled block left behind.
        configure(8'h03, 6'd4, 1'b0, 8'h00, 5'd2);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h03);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'hFF);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h00);
        queue_cmd(cobs_sr_pkg::ACT_FINISH, 8'h00);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h11);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h22);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h33);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h44);
        drain();

        // The depth drops below the fill position, then runs complete, break and stay open.
        configure(8'h03, 6'd1, 1'b1, 8'h41, 5'd3);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h55);
        repeat (3) queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h41);
        repeat (2) queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h41);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h42);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h41);
        drain();

        // Replacement is switched off with a run still pending.
        configure(8'h00, 6'd32, 1'b0, 8'h41, 5'd0);
        queue_cmd(cobs_sr_pkg::ACT_WRITE, 8'h41);
        queue_cmd(cobs_sr_pkg::ACT_FINISH, 8'h00);
        drain();

        hold_trigger = cmds_issued + 12;
        for (int p = 0; p < 6; p++) begin
            delim = 8'($urandom);
            depth = 6'($urandom_range(2, 32));
            rep = 1'b1;
            rb = 8'($urandom);
            rl = 5'($urandom_range(1, 16));
            case (p)
                0: delim = 8'h00;
                1: begin
                    delim = 8'hFF;
                    depth = 6'd2;
                    rb = 8'hFF;
                    rl = 5'd16;
                end
                2: begin
                    depth = 6'd63;
                    rb = 8'h00;
                    rl = 5'd0;
                end
                3: begin
                    depth = 6'd0;
                    rl = 5'd31;
                end
                4: begin
                    depth = 6'($urandom_range(0, 63));
                    rep = 1'($urandom_range(0, 1));
                    rl = 5'($urandom_range(0, 31));
                end
                default: quiet = 1'b1;
            endcase
            configure(delim, depth, rep, rb, rl);
            random_phase(20);
            drain();
        end

        $display("Encoded %0d commands into %0d checked output beats under %0d register settings.",
                 cmds_accepted, beats_checked, settings_used);
        $display("Runs, delimiters, finishes and depth changes were all exercised.");
        if (mismatch_count == 0 && coded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### cobs_sr_stream_encoder_top.f
rtl/cobs_sr_pkg.sv
rtl/cobs_sr_front.sv
rtl/cobs_sr_cmdq.sv
rtl/cobs_sr_back.sv
rtl/cobs_sr_stream_encoder_top.sv
sim/cobs_sr_stream_encoder_top_tb.sv
